>>> design/salsa20_stream_cipher_top_macros.svh
// assertion macros for the salsa20 stream cipher
`ifndef SALSA20_STREAM_CIPHER_TOP_MACROS_SVH
`define SALSA20_STREAM_CIPHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define S20_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define S20_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define S20_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define S20_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/s20sc_pkg.sv
`timescale 1ns / 1ps
package s20sc_pkg;
    localparam int CORE_ROUNDS_DEF = 20;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_LONG  = 3'd4;
    localparam logic [2:0] REG_NONCE = 3'd5;
    localparam logic [2:0] REG_START = 3'd6;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] TAU1   = 32'h3120646e;
    localparam logic [31:0] TAU2   = 32'h79622d36;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    // classified request handed from front to back
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic        new_block;
        logic        restart;
        logic [2:0]  slot;
    } req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_FINAL,
        BK_OUT
    } bk_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [127:0] qr(input logic [127:0] q);
        logic [31:0] a, b, c, d;
        a = q[31:0];
        b = q[63:32];
        c = q[95:64];
        d = q[127:96];
        b = b ^ rotl(a + d, 7);
        c = c ^ rotl(b + a, 9);
        d = d ^ rotl(c + b, 13);
        a = a ^ rotl(d + c, 18);
        qr = {d, c, b, a};
    endfunction
endpackage

>>> design/salsa20_stream_cipher_top.sv
`timescale 1ns / 1ps
// salsa20 stream cipher, one 8-byte request per handshake
// a request opening a block passes the round, final and output states; other requests go straight to output
// the back takes one request at a time and does not take the next until it is through with the last,
// its rounds run on the single shared round unit (one column or row round per cycle while in the round state)
// reset: asynchronous active low, registers to defaults, long key on, no message open
module salsa20_stream_cipher_top #(
    parameter int CORE_ROUNDS = s20sc_pkg::CORE_ROUNDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_chunk,
    input  logic [3:0]  byte_count,
    input  logic        last_in_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] cipher_chunk,
    output logic [3:0]  out_byte_count,
    output logic        out_last
);
    // configuration registers
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg, start_reg;
    logic        long_reg;

    // front to back queue
    logic            q_valid, q_ready;
    s20sc_pkg::req_t q_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            long_reg <= 1'b1;
            nonce_reg <= '0;
            start_reg <= '0;
        end
        else if (cfg_we)
        begin
            // indexes beyond the list are ignored
            unique case (cfg_index)
                s20sc_pkg::REG_KEY0:  key0_reg <= cfg_data;
                s20sc_pkg::REG_KEY1:  key1_reg <= cfg_data;
                s20sc_pkg::REG_KEY2:  key2_reg <= cfg_data;
                s20sc_pkg::REG_KEY3:  key3_reg <= cfg_data;
                s20sc_pkg::REG_LONG:  long_reg <= cfg_data[0];
                s20sc_pkg::REG_NONCE: nonce_reg <= cfg_data;
                s20sc_pkg::REG_START: start_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: tracks slot and message start, queues requests
    s20sc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_chunk(data_chunk), .byte_count(byte_count),
        .last_in_message(last_in_message),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    // back: keystream core and xor
    s20sc_back #(.CORE_ROUNDS(CORE_ROUNDS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .key0(key0_reg), .key1(key1_reg), .key2(key2_reg), .key3(key3_reg),
        .long_key_cfg(long_reg), .nonce(nonce_reg), .start_ctr(start_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .cipher_chunk(cipher_chunk), .out_byte_count(out_byte_count),
        .out_last(out_last)
    );
endmodule

>>> design/s20sc_front.sv
`timescale 1ns / 1ps
`include "salsa20_stream_cipher_top_macros.svh"
module s20sc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [63:0]      data_chunk,
    input  logic [3:0]       byte_count,
    input  logic             last_in_message,
    output logic             q_valid,
    input  logic             q_ready,
    output s20sc_pkg::req_t  q_req
);
    localparam int DEPTH = s20sc_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(DEPTH);

    s20sc_pkg::req_t   mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]       fill_reg;
    logic [2:0]        pos_reg;
    logic              in_msg_reg;
    logic              push, pop;
    s20sc_pkg::req_t   req;

    assign in_ready = (fill_reg != (AW+1)'(DEPTH));
    assign push = in_valid && in_ready;
    assign q_valid = (fill_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_req = mem_reg[rd_ptr_reg];

    always_comb
    begin
        req.data = data_chunk;
        req.count = byte_count;
        req.last = last_in_message;
        req.restart = !in_msg_reg;
        req.slot = in_msg_reg ? pos_reg : 3'd0;
        req.new_block = (req.slot == 3'd0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
            pos_reg <= '0;
            in_msg_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
                pos_reg <= req.slot + 3'd1;
                in_msg_reg <= !last_in_message;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    `S20_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, fill_reg <= (AW+1)'(DEPTH))
    `S20_ASSERT_NEXT(a_pos_follow, clk, rst_n, push, pos_reg == $past(req.slot) + 3'd1)
    `S20_ASSERT_IMP(a_restart_slot, clk, rst_n, push && !in_msg_reg, req.new_block)
endmodule

>>> design/s20sc_back.sv
`timescale 1ns / 1ps
`include "salsa20_stream_cipher_top_macros.svh"
module s20sc_back #(
    parameter int CORE_ROUNDS = s20sc_pkg::CORE_ROUNDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  s20sc_pkg::req_t  q_req,
    input  logic [63:0]      key0,
    input  logic [63:0]      key1,
    input  logic [63:0]      key2,
    input  logic [63:0]      key3,
    input  logic             long_key_cfg,
    input  logic [63:0]      nonce,
    input  logic [63:0]      start_ctr,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      cipher_chunk,
    output logic [3:0]       out_byte_count,
    output logic             out_last
);
    localparam int RW = $clog2(CORE_ROUNDS + 1);

    s20sc_pkg::bk_state_t state_reg, state_next;
    logic [31:0]      x_reg [16];
    logic [31:0]      in_reg [16];
    logic [31:0]      ks_reg [16];
    logic [RW-1:0]    round_reg;
    logic [63:0]      blk_reg;
    s20sc_pkg::req_t  cur_reg;
    logic             out_valid_reg;
    logic [63:0]      cipher_reg;
    logic [3:0]       cnt_reg;
    logic             last_reg;
    logic [31:0]      init [16];
    logic [31:0]      xr [16];
    logic [63:0]      hi_lo, hi_hi, ctr;
    logic [63:0]      ks, mask;
    logic             take, emit;

    assign q_ready = (state_reg == s20sc_pkg::BK_IDLE);
    assign take = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign cipher_chunk = cipher_reg;
    assign out_byte_count = cnt_reg;
    assign out_last = last_reg;

    always_comb
    begin
        hi_lo = long_key_cfg ? key2 : key0;
        hi_hi = long_key_cfg ? key3 : key1;
        ctr = q_req.restart ? start_ctr : blk_reg;
        init[0] = s20sc_pkg::SIGMA0;
        init[5] = long_key_cfg ? s20sc_pkg::SIGMA1 : s20sc_pkg::TAU1;
        init[10] = long_key_cfg ? s20sc_pkg::SIGMA2 : s20sc_pkg::TAU2;
        init[15] = s20sc_pkg::SIGMA3;
        init[1] = key0[31:0];
        init[2] = key0[63:32];
        init[3] = key1[31:0];
        init[4] = key1[63:32];
        init[11] = hi_lo[31:0];
        init[12] = hi_lo[63:32];
        init[13] = hi_hi[31:0];
        init[14] = hi_hi[63:32];
        init[6] = nonce[31:0];
        init[7] = nonce[63:32];
        init[8] = ctr[31:0];
        init[9] = ctr[63:32];
    end

    // one column or row round per cycle while in the round state
    always_comb
    begin
        logic [127:0] r0, r1, r2, r3;
        if (round_reg[0] == 1'b0)
        begin
            r0 = s20sc_pkg::qr({x_reg[12], x_reg[8], x_reg[4], x_reg[0]});
            r1 = s20sc_pkg::qr({x_reg[1], x_reg[13], x_reg[9], x_reg[5]});
            r2 = s20sc_pkg::qr({x_reg[6], x_reg[2], x_reg[14], x_reg[10]});
            r3 = s20sc_pkg::qr({x_reg[11], x_reg[7], x_reg[3], x_reg[15]});
            {xr[12], xr[8], xr[4], xr[0]} = r0;
            {xr[1], xr[13], xr[9], xr[5]} = r1;
            {xr[6], xr[2], xr[14], xr[10]} = r2;
            {xr[11], xr[7], xr[3], xr[15]} = r3;
        end
        else
        begin
            r0 = s20sc_pkg::qr({x_reg[3], x_reg[2], x_reg[1], x_reg[0]});
            r1 = s20sc_pkg::qr({x_reg[4], x_reg[7], x_reg[6], x_reg[5]});
            r2 = s20sc_pkg::qr({x_reg[9], x_reg[8], x_reg[11], x_reg[10]});
            r3 = s20sc_pkg::qr({x_reg[14], x_reg[13], x_reg[12], x_reg[15]});
            {xr[3], xr[2], xr[1], xr[0]} = r0;
            {xr[4], xr[7], xr[6], xr[5]} = r1;
            {xr[9], xr[8], xr[11], xr[10]} = r2;
            {xr[14], xr[13], xr[12], xr[15]} = r3;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            s20sc_pkg::BK_IDLE:
                if (take)
                begin
                    state_next = q_req.new_block ? s20sc_pkg::BK_ROUND : s20sc_pkg::BK_OUT;
                end
            s20sc_pkg::BK_ROUND:
                if (round_reg == RW'(CORE_ROUNDS - 1))
                begin
                    state_next = s20sc_pkg::BK_FINAL;
                end
            s20sc_pkg::BK_FINAL:
                state_next = s20sc_pkg::BK_OUT;
            s20sc_pkg::BK_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    state_next = s20sc_pkg::BK_IDLE;
                end
            default:
                state_next = s20sc_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        emit = (state_reg == s20sc_pkg::BK_OUT) && (!out_valid_reg || out_ready);
        ks = {ks_reg[{cur_reg.slot, 1'b1}], ks_reg[{cur_reg.slot, 1'b0}]};
        if (cur_reg.count >= 4'd8)
        begin
            mask = '1;
        end
        else
        begin
            mask = (64'd1 << {cur_reg.count[2:0], 3'd0}) - 64'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= q_req;
            if (q_req.new_block)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    x_reg[i] <= init[i];
                    in_reg[i] <= init[i];
                end
            end
        end
        else if (state_reg == s20sc_pkg::BK_ROUND)
        begin
            for (int i = 0; i < 16; i++)
            begin
                x_reg[i] <= xr[i];
            end
        end
        if (state_reg == s20sc_pkg::BK_FINAL)
        begin
            for (int i = 0; i < 16; i++)
            begin
                ks_reg[i] <= x_reg[i] + in_reg[i];
            end
        end
        if (emit)
        begin
            cipher_reg <= (cur_reg.data ^ ks) & mask;
            cnt_reg <= cur_reg.count;
            last_reg <= cur_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= s20sc_pkg::BK_IDLE;
            round_reg <= '0;
            blk_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                round_reg <= '0;
                if (q_req.new_block)
                begin
                    blk_reg <= ctr + 64'd1;
                end
            end
            else if (state_reg == s20sc_pkg::BK_ROUND)
            begin
                round_reg <= round_reg + 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `S20_ASSERT_IMP(a_round_bound, clk, rst_n, state_reg == s20sc_pkg::BK_ROUND,
        round_reg < RW'(CORE_ROUNDS))
    `S20_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid_reg && !out_ready,
        out_valid_reg && $stable(cipher_reg))
    `S20_ASSERT_NEXT(a_final_to_out, clk, rst_n, state_reg == s20sc_pkg::BK_FINAL,
        state_reg == s20sc_pkg::BK_OUT)
endmodule
